// File: src/nsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared constants, register indexes and control types of the Newton square
// root unit.
// ----------------------------------------------------------------------------
package nsr_pkg;

   // default number format: unsigned Q16.16
   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // configuration register layout
   localparam int TOL_W      = 16;
   localparam int STEP_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MAX_STEPS  = 64;

   localparam logic [TOL_W-1:0]  TOLERANCE_RESET  = TOL_W'(1);
   localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = STEP_W'(40);

   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT = CSR_IDX_W'(1);

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PREP   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture radicand and initial guess
      logic div_start;  // launch a division of radicand by guess
      logic emit;       // write result register and advance the guess
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic held_zero;  // captured radicand is zero
      logic div_done;   // quotient ready
      logic step_last;  // result about to be written ends this item
      logic out_free;   // result register can take a new item
   } status_type;

endpackage
`default_nettype wire

// File: src/nsr_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_divider
// Restoring divider, one quotient bit per cycle: floor(n * 2^FRAC_BITS / d),
// saturated to all ones when the quotient does not fit in VALUE_WIDTH bits.
// ----------------------------------------------------------------------------
module nsr_divider #(
   parameter int FRAC_BITS   = nsr_pkg::FRAC_BITS_DEFAULT,
   parameter int VALUE_WIDTH = nsr_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] dividend,
   input  wire logic [VALUE_WIDTH-1:0] divisor,
   output logic                        done,
   output logic [VALUE_WIDTH-1:0]      quotient
);
   import nsr_pkg::*;

   localparam int DIV_STEPS = VALUE_WIDTH + FRAC_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   logic [VALUE_WIDTH:0]   rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] num_ff, num_in;
   logic [VALUE_WIDTH-1:0] den_ff, den_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   sat_ff, sat_in;
   logic                   done_ff, done_in;

   logic [VALUE_WIDTH:0]   shifted;
   logic                   fits;

   // one restoring step: shift in the next numerator bit, trial subtract
   always_comb begin
      shifted = {rem_ff[VALUE_WIDTH-1:0], num_ff[VALUE_WIDTH-1]};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = '0;
         num_in  = dividend;
         den_in  = divisor;
         cnt_in  = CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? (shifted - {1'b0, den_ff}) : shifted;
         sat_in = sat_ff | quo_ff[VALUE_WIDTH-1];
         quo_in = {quo_ff[VALUE_WIDTH-2:0], fits};
         num_in = {num_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      num_ff <= num_in;
      den_ff <= den_in;
      sat_ff <= sat_in;
   end

   assign done     = done_ff;
   assign quotient = sat_ff ? '1 : quo_ff;

endmodule
`default_nettype wire

// File: src/nsr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_datapath
// Guess register, step counter, stop tests and result register of the Newton
// square root unit, with the shared divider.
// ----------------------------------------------------------------------------
module nsr_datapath #(
   parameter int FRAC_BITS   = nsr_pkg::FRAC_BITS_DEFAULT,
   parameter int VALUE_WIDTH = nsr_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire nsr_pkg::cmd_type            cmd,
   output nsr_pkg::status_type              status,
   input  wire logic [nsr_pkg::TOL_W-1:0]   tolerance,
   input  wire logic [nsr_pkg::STEP_W-1:0]  step_limit,
   input  wire logic [VALUE_WIDTH-1:0]      req_radicand,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [VALUE_WIDTH-1:0]           rsp_approximation,
   output logic                             rsp_last_result,
   output logic                             rsp_limit_hit
);
   import nsr_pkg::*;

   // wide enough to hold 1.0 even when it exceeds the value range
   localparam int CW = (VALUE_WIDTH > FRAC_BITS) ? VALUE_WIDTH + 1 : FRAC_BITS + 1;
   localparam int DW = (VALUE_WIDTH > TOL_W) ? VALUE_WIDTH : TOL_W;
   localparam logic [CW-1:0] ONE_WIDE = CW'(1) << FRAC_BITS;

   logic [VALUE_WIDTH-1:0] held_ff;
   logic [VALUE_WIDTH-1:0] guess_ff, guess_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   out_valid_ff, out_valid_in;
   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic                   out_last_ff, out_limit_ff;

   logic [VALUE_WIDTH-1:0] quotient;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] start_guess;
   logic [VALUE_WIDTH:0]   sum;
   logic [VALUE_WIDTH-1:0] next_guess;
   logic [VALUE_WIDTH-1:0] drop;
   logic                   converged;
   logic [STEP_W-1:0]      limit_eff;
   logic                   at_limit;
   logic                   held_zero;
   logic                   out_free;

   nsr_divider #(
      .FRAC_BITS   (FRAC_BITS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (held_ff),
      .divisor  (cmd.emit ? next_guess : guess_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // start at max(n, 1.0); 1.0 is cut to the value range
   assign start_guess = (CW'(req_radicand) > ONE_WIDE)
                        ? req_radicand : ONE_WIDE[VALUE_WIDTH-1:0];

   // average of guess and quotient, rounded down, and the stop tests
   always_comb begin
      sum = {1'b0, guess_ff >> 1} + {1'b0, quotient >> 1}
          + (VALUE_WIDTH + 1)'(guess_ff[0] & quotient[0]);
      next_guess = sum[VALUE_WIDTH-1:0];
      drop       = guess_ff - next_guess;
      converged  = !(guess_ff >= next_guess && DW'(drop) >= DW'(tolerance));
      priority if (step_limit == '0) begin
         limit_eff = STEP_W'(1);
      end else if (step_limit > STEP_W'(MAX_STEPS)) begin
         limit_eff = STEP_W'(MAX_STEPS);
      end else begin
         limit_eff = step_limit;
      end
      at_limit = (step_ff + STEP_W'(1)) >= limit_eff;
   end

   assign held_zero = held_ff == '0;
   assign out_free  = !out_valid_ff || rsp_ready;

   // advance guess and step count
   always_comb begin
      guess_in = guess_ff;
      step_in  = step_ff;
      if (cmd.load) begin
         guess_in = start_guess;
         step_in  = '0;
      end else if (cmd.emit) begin
         guess_in = held_zero ? '0 : next_guess;
         step_in  = step_ff + STEP_W'(1);
      end
   end

   // result register: hold while stalled, drop when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      guess_ff <= guess_in;
      if (cmd.load) begin
         held_ff <= req_radicand;
      end
      if (cmd.emit) begin
         out_value_ff <= held_zero ? '0 : next_guess;
         out_last_ff  <= held_zero | converged | at_limit;
         out_limit_ff <= !held_zero & !converged & at_limit;
      end
   end

   always_comb begin
      status.held_zero = held_zero;
      status.div_done  = div_done;
      status.step_last = held_zero | converged | at_limit;
      status.out_free  = out_free;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_approximation = out_value_ff;
   assign rsp_last_result   = out_last_ff;
   assign rsp_limit_hit     = out_limit_ff;

endmodule
`default_nettype wire

// File: src/nsr_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_controller
// Sequencer of the Newton square root unit: accept an item, run divisions,
// emit each approximation and stop on convergence or the step limit.
// ----------------------------------------------------------------------------
module nsr_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire nsr_pkg::status_type status,
   output nsr_pkg::cmd_type         cmd
);
   import nsr_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.emit      = 1'b0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // a zero radicand skips the divider
            if (status.held_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait for room in the result register
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.step_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIVIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: src/newton_square_root_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// newton_square_root_unit
// Square root of an unsigned fixed-point value by Newton steps, one result
// item per step.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel takes one radicand item (unsigned, FRAC_BITS fractional bits).
//   rsp_* channel returns every approximation in turn; rsp_last_result marks
//   the final one and rsp_limit_hit is set on it when the step limit, not
//   convergence, ended the run. A zero radicand gives one result of zero.
//   csr_* writes tolerance (index 0) and step_limit (index 1); write only
//   while idle. csr_ready is always high; other indexes are ignored.
// Sequencing:
//   Each Newton step costs one division in the bit-serial divider, plus
//   control; a zero radicand skips the divider.
//   One item is worked on at a time; req_ready is high only when idle.
// Reset and stall:
//   Reset (synchronous) empties the result register, returns to idle and
//   restores tolerance 1 and step_limit 40. When rsp_ready is low the current
//   result is held, the next division still runs, and emission waits.
// ----------------------------------------------------------------------------
module newton_square_root_unit #(
   parameter int FRAC_BITS   = nsr_pkg::FRAC_BITS_DEFAULT,
   parameter int VALUE_WIDTH = nsr_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [VALUE_WIDTH-1:0]          req_radicand,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [VALUE_WIDTH-1:0]               rsp_approximation,
   output logic                                 rsp_last_result,
   output logic                                 rsp_limit_hit,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [nsr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [nsr_pkg::CSR_DATA_W-1:0]  csr_data
);
   import nsr_pkg::*;

   logic [TOL_W-1:0]  tolerance_ff;
   logic [STEP_W-1:0] step_limit_ff;
   cmd_type           cmd;
   status_type        status;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff  <= TOLERANCE_RESET;
         step_limit_ff <= STEP_LIMIT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_TOLERANCE) begin
            tolerance_ff <= csr_data[TOL_W-1:0];
         end
         if (csr_index == CSR_STEP_LIMIT) begin
            step_limit_ff <= csr_data[STEP_W-1:0];
         end
      end
   end

   nsr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nsr_datapath #(
      .FRAC_BITS   (FRAC_BITS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .tolerance         (tolerance_ff),
      .step_limit        (step_limit_ff),
      .req_radicand      (req_radicand),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_approximation (rsp_approximation),
      .rsp_last_result   (rsp_last_result),
      .rsp_limit_hit     (rsp_limit_hit)
   );

endmodule
`default_nettype wire
